### sv/dd_pkg.sv
// Package with widths, constants and calendar helper functions for the date difference block.
`default_nettype none

package dd_pkg;

	localparam int unsigned YearW  = 14;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned OrdW   = 23;
	localparam int unsigned DiffW  = 23;
	localparam int unsigned MofsW  = 10;
	localparam int unsigned LeapW  = 13;
	localparam int unsigned DaysPerYear = 365;
	localparam int unsigned FebMonth    = 2;
	localparam int unsigned MonthsPerYear = 12;

	typedef logic [YearW-1:0]  year_t;
	typedef logic [MonthW-1:0] month_t;
	typedef logic [DayW-1:0]   day_t;
	typedef logic [OrdW-1:0]   ord_t;
	typedef logic [MofsW-1:0]  mofs_t;
	typedef logic [LeapW-1:0]  leapdays_t;
	typedef logic signed [DiffW-1:0] diff_t;

	// Month number forced into 1..12: zero reads as January, above twelve as December.
	function automatic month_t clamp_month(input month_t m);
		month_t r;
		if (m == '0) begin
			r = month_t'(1);
		end else if (m > month_t'(MonthsPerYear)) begin
			r = month_t'(MonthsPerYear);
		end else begin
			r = m;
		end
		return r;
	endfunction

	// Days of a common year that come before the first of the given month (1..12).
	function automatic logic [8:0] days_before_month(input month_t m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/date_difference_days.sv
// Top level of the date difference block: a four-stage pipeline from two dates to a signed day count.
`default_nettype none

// The block takes two calendar dates per transfer and returns the signed number of days from
// the first date to the second (positive when the second date is later). Every year divisible
// by four counts as a leap year, year 0 included. One transfer is accepted per clock cycle
// while the output side does not stall, and each passes through four registers: stage one forms
// year times 365, the leap days before the year and the day offset within the year; stage two
// adds these into a day ordinal for each date; stage three subtracts the ordinals; the output
// register saturates the difference to the 23-bit range. Each stage holds its item while the
// next one is full and stalled, so a stall on the output side backs up only as far as needed
// and nothing is dropped or repeated. Month zero reads as January, months above twelve as
// December, and out-of-range days enter the count linearly.
module date_difference_days (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire dd_pkg::year_t  year_a,
	input  wire dd_pkg::month_t month_a,
	input  wire dd_pkg::day_t   day_a,
	input  wire dd_pkg::year_t  year_b,
	input  wire dd_pkg::month_t month_b,
	input  wire dd_pkg::day_t   day_b,
	output logic                out_valid,
	input  wire                 out_stall,
	output dd_pkg::diff_t       day_difference
);
	import dd_pkg::*;

	// Index 0 carries the first date, index 1 the second.
	year_t  year_in  [2];
	month_t month_in [2];
	day_t   day_in   [2];

	ord_t      yr365_c    [2];
	leapdays_t leapdays_c [2];
	mofs_t     mofs_c     [2];

	ord_t      yr365_s1    [2];
	leapdays_t leapdays_s1 [2];
	mofs_t     mofs_s1     [2];
	ord_t      ord_s2      [2];
	logic signed [DiffW:0] diff_s3;
	diff_t     day_difference_q;

	logic valid_s1, valid_s2, valid_s3, valid_q;
	logic ready_s1, ready_s2, ready_s3, ready_q;

	assign year_in[0]  = year_a;
	assign year_in[1]  = year_b;
	assign month_in[0] = month_a;
	assign month_in[1] = month_b;
	assign day_in[0]   = day_a;
	assign day_in[1]   = day_b;

	// A stage may take a new item when it is empty or its item moves on in this cycle.
	assign ready_q  = !valid_q || !out_stall;
	assign ready_s3 = !valid_s3 || ready_q;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// Stage one logic: the three parts of each date's ordinal, computed independently.
	// The leap-day sum is one bit wider than the year so that years near the top of the
	// field do not wrap.
	always_comb begin
		month_t     m;
		logic       leap;
		logic [8:0] dbm;
		for (int i = 0; i < 2; i++) begin
			m             = clamp_month(month_in[i]);
			leap          = (year_in[i][1:0] == 2'b00);
			dbm           = days_before_month(m);
			yr365_c[i]    = ord_t'(year_in[i]) * ord_t'(DaysPerYear);
			leapdays_c[i] = leapdays_t'(((YearW+1)'(year_in[i]) + (YearW+1)'(3)) >> 2);
			mofs_c[i]     = mofs_t'(dbm) + mofs_t'(day_in[i])
				+ mofs_t'(leap && (m > month_t'(FebMonth)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_q) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			for (int i = 0; i < 2; i++) begin
				yr365_s1[i]    <= yr365_c[i];
				leapdays_s1[i] <= leapdays_c[i];
				mofs_s1[i]     <= mofs_c[i];
			end
		end
		if (ready_s2 && valid_s1) begin
			for (int i = 0; i < 2; i++) begin
				ord_s2[i] <= yr365_s1[i] + ord_t'(leapdays_s1[i]) + ord_t'(mofs_s1[i]);
			end
		end
		if (ready_s3 && valid_s2) begin
			diff_s3 <= $signed({1'b0, ord_s2[1]}) - $signed({1'b0, ord_s2[0]});
		end
		if (ready_q && valid_s3) begin
			// The two top bits disagree exactly when the difference leaves the 23-bit range.
			if (diff_s3[DiffW] != diff_s3[DiffW-1]) begin
				day_difference_q <= diff_s3[DiffW] ? {1'b1, {(DiffW-1){1'b0}}}
					: {1'b0, {(DiffW-1){1'b1}}};
			end else begin
				day_difference_q <= diff_s3[DiffW-1:0];
			end
		end
	end

	assign out_valid      = valid_q;
	assign day_difference = day_difference_q;

endmodule

`default_nettype wire

### verif/date_difference_days_tb.sv
// Self-checking testbench for the date difference block: directed calendar edges, random dates.
`default_nettype none

module date_difference_days_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dd_pkg::*;

	// Lengths of the months in a common year. February gains a day in every year divisible by
	// four, year 0 included.
	localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int DiffMax = 2 ** (DiffW - 1) - 1;
	localparam int DiffMin = -(2 ** (DiffW - 1));
	localparam int unsigned YearMax = 2 ** YearW - 1;
	localparam int unsigned DrainCycles = 20;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	year_t  year_a;
	month_t month_a;
	day_t   day_a;
	year_t  year_b;
	month_t month_b;
	day_t   day_b;
	logic   out_valid;
	logic   out_stall;
	diff_t  day_difference;

	// Day counts that the block still owes, oldest first.
	diff_t pending_diffs [$];
	int unsigned mismatch_count;

	// Sender pacing: the sender runs in bursts and, when gaps are on, drops valid for a random
	// number of cycles between bursts.
	bit          sender_gaps_on;
	int unsigned burst_left;

	// Receiver pacing: its own stall pattern, which can be switched off, plus a long hold that
	// a test can request and that the receiver counts down by itself.
	bit          receiver_stalls_on;
	int unsigned hold_cycles_left;

	date_difference_days i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.year_a         (year_a),
		.month_a        (month_a),
		.day_a          (day_a),
		.year_b         (year_b),
		.month_b        (month_b),
		.day_b          (day_b),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.day_difference (day_difference)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Day ordinal of a date: whole years, leap days of the years before, days of the months
	// before and the day itself. Month zero counts as January and months past twelve as
	// December; days outside the month simply add on, so day 0 is the last day of the month
	// before and day 31 of a short month spills into the next one.
	function automatic int calendar_ordinal(input year_t y, input month_t m, input day_t d);
		int unsigned mon;
		int unsigned ord;
		int unsigned i;
		mon = int'(m);
		if (mon == 0) begin
			mon = 1;
		end else if (mon > 12) begin
			mon = 12;
		end
		ord = int'(y) * 365 + ((int'(y) + 3) >> 2) + int'(d);
		for (i = 1; i < mon; i++) begin
			ord += MonthDays[i - 1];
		end
		if (y[1:0] == 2'b00 && mon > 2) begin
			ord += 1;
		end
		return int'(ord);
	endfunction

	// Signed days from date a to date b, saturated to the width of the output. Saturation can
	// only happen when a year lies beyond 9999.
	function automatic diff_t expected_day_difference(input year_t ya, input month_t ma,
			input day_t da, input year_t yb, input month_t mb, input day_t db);
		int span;
		span = calendar_ordinal(yb, mb, db) - calendar_ordinal(ya, ma, da);
		if (span > DiffMax) begin
			span = DiffMax;
		end else if (span < DiffMin) begin
			span = DiffMin;
		end
		return diff_t'(span);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Offers one pair of dates and holds it until the block takes it. Inputs change at the
	// falling edge; the transfer is seen at the rising edge where valid is high and stall low.
	// Within a burst valid stays high from one item to the next, so it is never lowered and
	// raised again at the same edge.
	task automatic send_dates(input year_t ya, input month_t ma, input day_t da,
			input year_t yb, input month_t mb, input day_t db);
		int unsigned gap;
		if (sender_gaps_on && burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			gap = $urandom_range(0, 6);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		year_a   <= ya;
		month_a  <= ma;
		day_a    <= da;
		year_b   <= yb;
		month_b  <= mb;
		day_b    <= db;
		do begin
			@(posedge clk);
		end while (in_stall);
		pending_diffs.push_back(expected_day_difference(ya, ma, da, yb, mb, db));
		if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	// Random valid date: any year in 0..9999, any month, a day that exists in that month.
	task automatic pick_valid_date(output year_t y, output month_t m, output day_t d);
		int unsigned last_day;
		y = year_t'($urandom_range(0, 9999));
		m = month_t'($urandom_range(1, 12));
		last_day = MonthDays[m - 1];
		if (m == month_t'(FebMonth) && y[1:0] == 2'b00) begin
			last_day++;
		end
		d = day_t'($urandom_range(1, last_day));
	endtask

	// Widest spans of the valid range, equal dates, and the end of February in year 0 and in a
	// common year.
	task automatic test_calendar_extremes();
		send_dates(14'd2024, 4'd2, 5'd29, 14'd2024, 4'd2, 5'd29);
		send_dates(14'd0, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31);
		send_dates(14'd9999, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1);
		send_dates(14'd0, 4'd2, 5'd28, 14'd0, 4'd3, 5'd1);
		send_dates(14'd1, 4'd2, 5'd28, 14'd1, 4'd3, 5'd1);
		send_dates(14'd1900, 4'd2, 5'd29, 14'd2100, 4'd3, 5'd1);
		send_dates(14'd2023, 4'd12, 5'd31, 14'd2024, 4'd1, 5'd1);
		send_dates(14'd0, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1);
	endtask

	// Months outside 1..12 and days outside the month, which the block clamps or counts on.
	task automatic test_month_and_day_edges();
		send_dates(14'd2001, 4'd0, 5'd15, 14'd2001, 4'd1, 5'd15);
		send_dates(14'd2001, 4'd13, 5'd10, 14'd2001, 4'd12, 5'd10);
		send_dates(14'd2004, 4'd15, 5'd31, 14'd2004, 4'd0, 5'd0);
		send_dates(14'd2003, 4'd3, 5'd0, 14'd2003, 4'd2, 5'd28);
		send_dates(14'd2003, 4'd4, 5'd31, 14'd2003, 4'd5, 5'd1);
		send_dates(14'd2000, 4'd2, 5'd31, 14'd2000, 4'd3, 5'd2);
		send_dates(14'd0, 4'd1, 5'd0, 14'd0, 4'd0, 5'd31);
	endtask

	// Years past 9999 up to the top of the field, and the spans that saturate the output.
	task automatic test_year_overflow();
		send_dates(14'd9999, 4'd12, 5'd31, 14'd10000, 4'd1, 5'd1);
		send_dates(year_t'(YearMax), 4'd12, 5'd31, 14'd16380, 4'd2, 5'd29);
		send_dates(14'd0, 4'd1, 5'd1, year_t'(YearMax), 4'd15, 5'd31);
		send_dates(year_t'(YearMax), 4'd15, 5'd31, 14'd0, 4'd0, 5'd0);
		send_dates(14'd4800, 4'd1, 5'd1, year_t'(YearMax), 4'd12, 5'd31);
		send_dates(14'd11483, 4'd6, 5'd1, 14'd0, 4'd1, 5'd1);
	endtask

	// Mostly valid dates, half of them close together so that small and zero differences are
	// frequent. The first stretch runs with no idling on either side.
	task automatic test_random_valid_dates(input int unsigned count);
		year_t  ya, yb;
		month_t ma, mb;
		day_t   da, db;
		int unsigned n;
		for (n = 0; n < count; n++) begin
			sender_gaps_on     = (n >= 150);
			receiver_stalls_on = (n >= 150);
			pick_valid_date(ya, ma, da);
			pick_valid_date(yb, mb, db);
			if ($urandom_range(0, 1) == 0) begin
				yb = year_t'((int'(ya) + $urandom_range(0, 2)) % 10000);
			end
			if ($urandom_range(0, 15) == 0) begin
				{yb, mb, db} = {ya, ma, da};
			end
			send_dates(ya, ma, da, yb, mb, db);
		end
	endtask

	// Every field drawn over its full width, so out-of-range months, days and years mix freely.
	task automatic test_random_raw_fields(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++) begin
			send_dates(year_t'($urandom()), month_t'($urandom()), day_t'($urandom()),
				year_t'($urandom()), month_t'($urandom()), day_t'($urandom()));
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering back to back,
	// so the pipeline fills and the block has to stall its input without losing a transfer.
	task automatic test_long_output_hold();
		year_t  ya, yb;
		month_t ma, mb;
		day_t   da, db;
		int unsigned n;
		sender_gaps_on   = 1'b0;
		hold_cycles_left = 80;
		for (n = 0; n < 40; n++) begin
			pick_valid_date(ya, ma, da);
			pick_valid_date(yb, mb, db);
			send_dates(ya, ma, da, yb, mb, db);
		end
		sender_gaps_on = 1'b1;
	endtask

	// Receiver stall pattern: alternating runs of stalling and accepting with lengths of their
	// own, now and then a long free run. A requested long hold overrides the pattern.
	initial begin
		int unsigned run_left;
		bit          stalling;
		out_stall = 1'b0;
		run_left  = 0;
		stalling  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles_left > 0) begin
				out_stall <= 1'b1;
				hold_cycles_left--;
			end else begin
				if (run_left == 0) begin
					stalling = !stalling;
					if (stalling) begin
						run_left = $urandom_range(1, 6);
					end else if ($urandom_range(0, 3) == 0) begin
						run_left = $urandom_range(30, 80);
					end else begin
						run_left = $urandom_range(1, 12);
					end
				end
				run_left--;
				out_stall <= stalling && receiver_stalls_on;
			end
		end
	end

	// Every result the block hands over is compared with the oldest outstanding expectation.
	always @(posedge clk) begin
		diff_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_diffs.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", day_difference));
			end else begin
				want = pending_diffs.pop_front();
				if (day_difference !== want) begin
					report_mismatch($sformatf("day_difference got %0d, expected %0d",
						day_difference, want));
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		year_a             = '0;
		month_a            = '0;
		day_a              = '0;
		year_b             = '0;
		month_b            = '0;
		day_b              = '0;
		mismatch_count     = 0;
		sender_gaps_on     = 1'b1;
		burst_left         = 0;
		receiver_stalls_on = 1'b1;
		hold_cycles_left   = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_calendar_extremes();
		test_month_and_day_edges();
		test_year_overflow();
		test_random_valid_dates(1100);
		test_long_output_hold();
		test_random_raw_fields(300);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_diffs.size() != 0) begin
			@(posedge clk);
		end
		// Keep waiting for DrainCycles so that a stray extra result would still be caught.
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
